// File: hw/rtl/sfct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sfct_pkg;

  localparam int NumSensorsDefault = 8;
  localparam int FrameLen          = 12;
  localparam int CountOver         = 13;
  localparam int SumBytes          = 10;
  localparam int MsPerSec          = 1000;
  localparam int TankCountMax      = 8;
  localparam int TankCountReset    = 2;
  localparam int TimeoutMin        = 5;
  localparam int TimeoutMax        = 4294967;
  localparam int TimeoutReset      = 30;

  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_QUERY   = 1'b1;

  localparam logic [1:0] REG_TANK_COUNT = 2'd0;
  localparam logic [1:0] REG_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_TRAILING   = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_LEN = 2'd1,
    STATUS_BAD_SUM = 2'd2,
    STATUS_BAD_ID  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VERDICT,
    ST_SCAN,
    ST_DRAIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [15:0] level_x100;
    logic [15:0] batt_mv;
    logic [7:0]  batt_pct;
    logic [31:0] seen_ms;
  } entry_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  sensor_id;
    logic [15:0] level_x100;
    logic [15:0] batt_mv;
    logic [7:0]  batt_pct;
  } verdict_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [7:0]  sensor_id;
    logic [15:0] level_x100;
    logic [15:0] batt_mv;
    logic [7:0]  batt_pct;
    logic        online;
    logic [3:0]  online_count;
    logic [31:0] last_seen_ms;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/sfct_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sfct_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  byte_value;
  logic        last_byte;
  logic [2:0]  query_index;
  logic [31:0] now_ms;

  modport source (
    output valid, cmd, byte_value, last_byte, query_index, now_ms,
    input  ready
  );
  modport sink (
    input  valid, cmd, byte_value, last_byte, query_index, now_ms,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/sfct_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sfct_rsp_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [1:0]  status;
  logic [7:0]  sensor_id;
  logic [15:0] level_x100;
  logic [15:0] batt_mv;
  logic [7:0]  batt_pct;
  logic        online;
  logic [3:0]  online_count;
  logic [31:0] last_seen_ms;

  modport source (
    output valid, kind, status, sensor_id, level_x100, batt_mv, batt_pct,
           online, online_count, last_seen_ms,
    input  ready
  );
  modport sink (
    input  valid, kind, status, sensor_id, level_x100, batt_mv, batt_pct,
           online, online_count, last_seen_ms,
    output ready
  );
endinterface
`default_nettype wire

// File: hw/rtl/sfct_online_unit.sv
`timescale 1ns / 1ps
`default_nettype none
module sfct_online_unit
  import sfct_pkg::*;
(
  input  wire logic [31:0] seen_ms,
  input  wire logic [31:0] now_ms,
  input  wire logic [31:0] limit_ms,
  output logic             online
);

  logic [31:0] elapsed;

  // Wrapping subtract, so an entry stamped just before a counter wrap stays online.
  assign elapsed = now_ms - seen_ms;
  assign online  = (seen_ms != 32'd0) && (elapsed <= limit_ms);

endmodule
`default_nettype wire

// File: hw/rtl/sfct_entry_mem.sv
`timescale 1ns / 1ps
`default_nettype none
module sfct_entry_mem
  import sfct_pkg::*;
#(
  parameter int NUM_SENSORS = NumSensorsDefault
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst,
  input  wire logic                                          we,
  input  wire logic [((NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1)-1:0] waddr,
  input  wire entry_t                                        wdata,
  input  wire logic [((NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1)-1:0] raddr,
  output entry_t                                             rdata
);

  entry_t                   mem [NUM_SENSORS];
  logic [NUM_SENSORS-1:0]   written;
  entry_t                   rd_q;
  logic                     rd_ok;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // An entry never written reads as all zero, which also means never seen.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_ok   <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_ok <= written[raddr];
    end
  end

  assign rdata = rd_ok ? rd_q : '0;

endmodule
`default_nettype wire

// File: hw/rtl/sfct_frame_collect.sv
`timescale 1ns / 1ps
`default_nettype none
module sfct_frame_collect
  import sfct_pkg::*;
#(
  parameter int NUM_SENSORS = NumSensorsDefault
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       take,
  input  wire logic [7:0] byte_value,
  input  wire logic       clear,
  input  wire logic       allow_trailing,
  output verdict_t        verdict
);

  localparam logic [7:0] MaxId = 8'(NUM_SENSORS);

  logic [7:0]  frame_store [FrameLen];
  logic [3:0]  byte_count;
  logic [15:0] sum;
  logic        bad_len;
  logic [15:0] crc;

  always_ff @(posedge clk) begin
    if (take && (byte_count < 4'(FrameLen))) begin
      frame_store[byte_count] <= byte_value;
    end
  end

  // The checksum accumulates as bytes arrive; the count sticks at one past a full frame.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      byte_count <= 4'd0;
      sum        <= 16'd0;
    end else if (take) begin
      if (byte_count < 4'(CountOver)) begin
        byte_count <= byte_count + 4'd1;
      end
      if (byte_count < 4'(SumBytes)) begin
        sum <= sum + {8'd0, byte_value};
      end
    end
  end

  assign bad_len = (byte_count < 4'(FrameLen)) ||
                   ((byte_count > 4'(FrameLen)) && !allow_trailing);
  assign crc     = {frame_store[11], frame_store[10]};

  always_comb begin
    verdict.sensor_id  = frame_store[0];
    verdict.level_x100 = {frame_store[6], frame_store[5]};
    verdict.batt_mv    = {frame_store[8], frame_store[7]};
    verdict.batt_pct   = frame_store[9];
    if (bad_len) begin
      verdict.status     = STATUS_BAD_LEN;
      verdict.level_x100 = 16'd0;
      verdict.batt_mv    = 16'd0;
      verdict.batt_pct   = 8'd0;
    end else if (sum != crc) begin
      verdict.status = STATUS_BAD_SUM;
    end else if ((frame_store[0] == 8'd0) || (frame_store[0] > MaxId)) begin
      verdict.status = STATUS_BAD_ID;
    end else begin
      verdict.status = STATUS_OK;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/sensor_frame_checker_table.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  Dir  Carries
// req      in   cmd, byte_value, last_byte, query_index, now_ms
// rsp      out  kind, status, sensor_id, level_x100, batt_mv, batt_pct,
//               online, online_count, last_seen_ms
// cfg_*    in   write enable, register index, write data
//
// A frame byte that is not last is taken in idle; a last byte adds the verdict
// and finish states. A query adds scan, drain and finish: the entry memory is
// read one entry per cycle in scan, judged by a single timeout compare unit.
// Reset is synchronous and clears the table, the frame count and registers.
// req is taken only while idle; a finished result waits in the output register
// and holds the block at its last cycle only while rsp stalls a second result.
module sensor_frame_checker_table
  import sfct_pkg::*;
#(
  parameter int NUM_SENSORS = NumSensorsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  sfct_req_if.sink         req,
  sfct_rsp_if.source       rsp,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [22:0] cfg_data
);

  localparam int AW          = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int TankCapInt  = (NUM_SENSORS < TankCountMax) ? NUM_SENSORS : TankCountMax;
  localparam int TankRstInt  = (TankCountReset < TankCapInt) ? TankCountReset : TankCapInt;
  localparam logic [3:0] TankCap   = 4'(TankCapInt);
  localparam logic [3:0] TankReset = 4'(TankRstInt);
  localparam logic [31:0] LimitReset = 32'(TimeoutReset * MsPerSec);
  localparam logic [7:0]  NumIdx     = 8'(NUM_SENSORS);

  state_t      state;
  state_t      state_next;

  logic [3:0]  tank_count;
  logic [31:0] limit_ms;
  logic        allow_trailing;
  logic [3:0]  tank_wr;
  logic [22:0] timeout_wr;

  logic        accept;
  logic        take;
  logic        clear;
  logic        mem_we;
  logic        issue;
  logic        load_out;

  logic [2:0]  qi;
  logic        q_ok;
  logic [31:0] now_q;
  logic [3:0]  step;
  logic        tag_valid;
  logic        tag_query;
  result_t     res;
  result_t     out_q;
  logic        out_valid;

  verdict_t    verdict;
  entry_t      wentry;
  entry_t      rentry;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic        online;

  // Configuration with clamping to the legal ranges.
  always_comb begin
    tank_wr = cfg_data[3:0];
    if (tank_wr < 4'd1) begin
      tank_wr = 4'd1;
    end
    if (tank_wr > TankCap) begin
      tank_wr = TankCap;
    end
    timeout_wr = cfg_data;
    if (timeout_wr < 23'(TimeoutMin)) begin
      timeout_wr = 23'(TimeoutMin);
    end
    if (timeout_wr > 23'(TimeoutMax)) begin
      timeout_wr = 23'(TimeoutMax);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tank_count     <= TankReset;
      limit_ms       <= LimitReset;
      allow_trailing <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TANK_COUNT: tank_count     <= tank_wr;
        REG_TIMEOUT:    limit_ms       <= {9'd0, timeout_wr} * 32'(MsPerSec);
        REG_TRAILING:   allow_trailing <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer.
  assign accept = req.valid && req.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (req.cmd == CMD_QUERY) begin
            state_next = ST_SCAN;
          end else if (req.last_byte) begin
            state_next = ST_VERDICT;
          end
        end
      end
      ST_VERDICT: state_next = ST_FIN;
      ST_SCAN: begin
        if (step == tank_count) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN: begin
        if (!out_valid || rsp.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    take      = 1'b0;
    clear     = 1'b0;
    mem_we    = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        take      = req.valid && (req.cmd == CMD_BYTE);
      end
      ST_VERDICT: begin
        clear  = 1'b1;
        mem_we = (verdict.status == STATUS_OK);
      end
      ST_SCAN:  issue = 1'b1;
      ST_DRAIN: ;
      ST_FIN:   load_out = !out_valid || rsp.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  sfct_frame_collect #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_collect (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .byte_value     (req.byte_value),
    .clear          (clear),
    .allow_trailing (allow_trailing),
    .verdict        (verdict)
  );

  assign waddr             = AW'(verdict.sensor_id - 8'd1);
  assign wentry.level_x100 = verdict.level_x100;
  assign wentry.batt_mv    = verdict.batt_mv;
  assign wentry.batt_pct   = verdict.batt_pct;
  assign wentry.seen_ms    = now_q;

  // Step zero reads the queried entry; later steps walk the counted entries.
  always_comb begin
    if (step == 4'd0) begin
      raddr = q_ok ? AW'(qi) : '0;
    end else begin
      raddr = AW'(step - 4'd1);
    end
  end

  sfct_entry_mem #(
    .NUM_SENSORS (NUM_SENSORS)
  ) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  sfct_online_unit u_online (
    .seen_ms  (rentry.seen_ms),
    .now_ms   (now_q),
    .limit_ms (limit_ms),
    .online   (online)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_valid <= 1'b0;
    end else begin
      tag_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    tag_query <= (step == 4'd0);
    if (accept) begin
      qi               <= req.query_index;
      q_ok             <= {5'd0, req.query_index} < NumIdx;
      now_q            <= req.now_ms;
      step             <= 4'd0;
      res.online_count <= 4'd0;
    end
    if (issue) begin
      step <= step + 4'd1;
    end
    if (state == ST_VERDICT) begin
      res.online_count   <= 4'd0;
      res.kind           <= KIND_VERDICT;
      res.status         <= verdict.status;
      res.sensor_id      <= verdict.sensor_id;
      res.level_x100     <= verdict.level_x100;
      res.batt_mv        <= verdict.batt_mv;
      res.batt_pct       <= verdict.batt_pct;
      res.online         <= 1'b0;
      res.last_seen_ms   <= (verdict.status == STATUS_OK) ? now_q : 32'd0;
    end
    if (tag_valid) begin
      if (tag_query) begin
        res.kind         <= KIND_QUERY;
        res.status       <= STATUS_OK;
        res.sensor_id    <= {5'd0, qi} + 8'd1;
        res.level_x100   <= q_ok ? rentry.level_x100 : 16'd0;
        res.batt_mv      <= q_ok ? rentry.batt_mv : 16'd0;
        res.batt_pct     <= q_ok ? rentry.batt_pct : 8'd0;
        res.online       <= q_ok && online;
        res.last_seen_ms <= q_ok ? rentry.seen_ms : 32'd0;
      end else if (online) begin
        res.online_count <= res.online_count + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.kind         = out_q.kind;
  assign rsp.status       = out_q.status;
  assign rsp.sensor_id    = out_q.sensor_id;
  assign rsp.level_x100   = out_q.level_x100;
  assign rsp.batt_mv      = out_q.batt_mv;
  assign rsp.batt_pct     = out_q.batt_pct;
  assign rsp.online       = out_q.online;
  assign rsp.online_count = out_q.online_count;
  assign rsp.last_seen_ms = out_q.last_seen_ms;

endmodule
`default_nettype wire
